### rtl/thsd_pkg.sv
package thsd_pkg;

    localparam int ScratchpadBytes = 9;
    localparam int PosW            = 4;

    localparam logic [PosW-1:0] LastPos = PosW'(ScratchpadBytes - 1);

    localparam logic [7:0] CrcPoly = 8'h8C;

    // resolution codes
    localparam logic [3:0] RES_10 = 4'd10;
    localparam logic [3:0] RES_11 = 4'd11;
    localparam logic [3:0] RES_12 = 4'd12;
    localparam logic [3:0] RES_RESET = RES_12;

    typedef struct packed {
        logic       ok;
        logic [7:0] lo;
        logic [7:0] hi;
    } t_frame;

    typedef struct packed {
        logic       status;
        logic       negative;
        logic [6:0] whole_degrees;
        logic [3:0] tenths;
    } t_result;

    // reflected CRC-8, one byte, LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] d;
        c = crc;
        d = b;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

### rtl/thsd_frame.sv
module thsd_frame (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_byte,
    output logic                   o_last,
    output thsd_pkg::t_frame       o_frame
);

    logic [7:0]                r_crc;
    logic [thsd_pkg::PosW-1:0] r_pos;
    logic [7:0]                r_lo;
    logic [7:0]                r_hi;

    logic [7:0] n_crc;
    logic [7:0] n_lo;
    logic [7:0] n_hi;

    always_comb begin
        n_crc = thsd_pkg::crc8_byte(r_crc, i_byte);
        n_lo  = (r_pos == '0) ? i_byte : r_lo;
        n_hi  = (r_pos == thsd_pkg::PosW'(1)) ? i_byte : r_hi;
    end

    assign o_last     = (r_pos >= thsd_pkg::LastPos);
    assign o_frame.ok = (n_crc == 8'h00);
    assign o_frame.lo = n_lo;
    assign o_frame.hi = n_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '0;
            r_pos <= '0;
            r_lo  <= '0;
            r_hi  <= '0;
        end else if (i_step) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
            if (o_last) begin
                r_crc <= '0;
                r_pos <= '0;
            end else begin
                r_crc <= n_crc;
                r_pos <= r_pos + thsd_pkg::PosW'(1);
            end
        end
    end

endmodule

### rtl/thsd_decode.sv
module thsd_decode (
    input  thsd_pkg::t_frame  i_frame,
    input  logic [3:0]        i_res,
    output thsd_pkg::t_result o_result
);

    logic [6:0]  sum;
    logic [14:0] prod;
    logic [3:0]  tenths;
    logic [7:0]  lo;

    always_comb begin
        lo  = i_frame.lo;
        sum = (lo[3] ? 7'd50 : 7'd0) + (lo[2] ? 7'd25 : 7'd0) + (lo[1] ? 7'd13 : 7'd0)
            + ((i_res == thsd_pkg::RES_12 && lo[0]) ? 7'd6 : 7'd0);
        // divide by ten: x*205 >> 11 is exact in 15 bits for x below 160
        prod = 15'(sum) * 15'd205;

        if (i_res == thsd_pkg::RES_12 || i_res == thsd_pkg::RES_11) begin
            tenths = prod[14:11];
        end else if (i_res == thsd_pkg::RES_10) begin
            tenths = (lo[3] ? 4'd5 : 4'd0) + (lo[2] ? 4'd3 : 4'd0);
        end else begin
            tenths = lo[3] ? 4'd5 : 4'd0;
        end

        o_result.status = !i_frame.ok;
        if (i_frame.ok) begin
            o_result.negative      = i_frame.hi[7];
            o_result.whole_degrees = {i_frame.hi[2:0], lo[7:4]};
            o_result.tenths        = tenths;
        end else begin
            o_result.negative      = 1'b0;
            o_result.whole_degrees = '0;
            o_result.tenths        = '0;
        end
    end

endmodule

### rtl/thermometer_scratchpad_decode_top.sv
// The last scratchpad byte passes from the input register into the result register,
// which drives m_axis_tvalid; a stall can hold it in the input register.
// Throughput: one byte per cycle; the byte-wide CRC update is combinational. The
// last byte of a frame waits while the result register is full and not drained.
// Reset (synchronous, active low) empties both registers, clears CRC and byte
// position, sets the resolution to 12 bits; s_axis_tready stays low until r_res is set.
module thermometer_scratchpad_decode_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,   // resolution_bits
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [0] negative, [7:1] whole_degrees,
                                       // [11:8] tenths, [15:12] zero
    output logic        m_axis_tuser   // status
);

    logic       r_res;
    logic [3:0] r_resolution;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    thsd_pkg::t_result r_out;

    logic              last;
    logic              advance;
    thsd_pkg::t_frame  frame;
    thsd_pkg::t_result result;

    // byte moves on unless it closes a frame and the result slot stays full
    assign advance       = r_in_valid && (!last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = r_res && (!r_in_valid || advance);

    thsd_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_last  (last),
        .o_frame (frame)
    );

    thsd_decode u_decode (
        .i_frame  (frame),
        .i_res    (r_resolution),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolution <= thsd_pkg::RES_RESET;
            r_res        <= 1'b0;
        end else begin
            r_res <= 1'b1;
            if (i_cfg_we) begin
                r_resolution <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && last) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {4'b0000, r_out.tenths, r_out.whole_degrees, r_out.negative};

endmodule
